/* rtl/adfp_pkg.sv */
`timescale 1ns / 1ps
// shared constants, result type and byte decode functions for the air data frame parser
// no dependencies
package adfp_pkg;

	localparam int unsigned HEX_DIGITS_DEF = 8;
	localparam int unsigned POS_W          = 4;
	localparam int unsigned COUNT_W        = 4;
	localparam int unsigned CHAN_W         = 4;
	localparam int unsigned WORD_W         = 32;

	localparam logic [7:0] START_A     = 8'h01;
	localparam logic [7:0] START_B     = 8'h02;
	localparam logic [7:0] START_C     = 8'h03;
	localparam logic [7:0] RETURN_BYTE = 8'h0D;

	localparam logic [COUNT_W-1:0] BATCH_RESET = 4'd12;

	localparam logic [1:0] CODE_A = 2'd1;
	localparam logic [1:0] CODE_B = 2'd2;
	localparam logic [1:0] CODE_C = 2'd3;

	localparam logic [CHAN_W-1:0] CHAN_CR      = 4'd9;
	localparam logic [CHAN_W-1:0] CHAN_QCR     = 4'd10;
	localparam logic [CHAN_W-1:0] CHAN_PSR     = 4'd11;
	localparam logic [CHAN_W-1:0] CHAN_UNKNOWN = 4'd12;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [WORD_W-1:0] raw_word;
		logic              batch_end;
	} frame_result_t;

	// bit 4 set means not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		v = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = {1'b0, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			v = {1'b0, b[3:0] + 4'd9};
		end
		return v;
	endfunction

	function automatic logic [CHAN_W-1:0] channel_of(input logic [1:0] start,
			input logic [3:0] label);
		logic [CHAN_W-1:0] c;
		c = CHAN_UNKNOWN;
		case (start)
			CODE_A: begin
				if (label >= 4'd1 && label <= 4'd9) c = label - 4'd1;
			end
			CODE_B: begin
				c = CHAN_CR;
			end
			CODE_C: begin
				if (label == 4'd1) c = CHAN_QCR;
				else if (label == 4'd2) c = CHAN_PSR;
			end
			default: begin
				c = CHAN_UNKNOWN;
			end
		endcase
		return c;
	endfunction

endpackage

/* rtl/adfp_frame_unit.sv */
`timescale 1ns / 1ps
// frame state, hex gathering and batch counting for one byte per step
// depends on adfp_pkg
module adfp_frame_unit #(
	parameter int unsigned HEX_DIGITS = adfp_pkg::HEX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [7:0]                    rx_byte,
	input  logic [adfp_pkg::COUNT_W-1:0]  batch_length,
	output logic                          produce,
	output adfp_pkg::frame_result_t       result
);
	import adfp_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEX_DIGITS + 2);

	logic [POS_W-1:0]   pos_q;
	logic [1:0]         start_q;
	logic [3:0]         label_q;
	logic [WORD_W-1:0]  acc_q;
	logic               stopped_q;
	logic [COUNT_W-1:0] count_q;

	logic               is_start;
	logic               is_return;
	logic [4:0]         hv;
	logic [COUNT_W-1:0] count_next;
	logic               end_hit;

	assign is_start   = (rx_byte == START_A) || (rx_byte == START_B) || (rx_byte == START_C);
	assign is_return  = (rx_byte == RETURN_BYTE);
	assign hv         = hex_value(rx_byte);
	assign produce    = !is_start && (pos_q == LAST_POS) && is_return;
	assign count_next = count_q + COUNT_W'(1);
	assign end_hit    = (count_next == batch_length);

	assign result.channel   = channel_of(start_q, label_q);
	assign result.raw_word  = acc_q;
	assign result.batch_end = end_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			start_q   <= '0;
			label_q   <= '0;
			acc_q     <= '0;
			stopped_q <= 1'b0;
			count_q   <= '0;
		end else if (step) begin
			if (is_start) begin
				start_q   <= rx_byte[1:0];
				label_q   <= '0;
				acc_q     <= '0;
				stopped_q <= 1'b0;
				pos_q     <= POS_W'(1);
			end else if (pos_q == '0) begin
				pos_q <= '0;
			end else if (pos_q == LAST_POS) begin
				pos_q <= '0;
				if (is_return) count_q <= end_hit ? '0 : count_next;
			end else if (is_return) begin
				pos_q <= '0;
			end else begin
				if (pos_q == POS_W'(1)) begin
					label_q <= rx_byte[3:0];
				end else if (!stopped_q) begin
					if (hv[4]) stopped_q <= 1'b1;
					else acc_q <= {acc_q[WORD_W-5:0], hv[3:0]};
				end
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

/* rtl/air_data_frame_parser_core.sv */
`timescale 1ns / 1ps
// Air data frame parser: takes one serial byte per word on the input channel and returns one
// result word (channel code, raw 32-bit hex value, batch end mark) for every complete frame,
// that is a start byte 0x01/0x02/0x03, a label byte, HEX_DIGITS hex characters and a carriage
// return. Each byte passes through the input register, then the frame update that loads the
// result register, and a new byte is taken every cycle; the only thing that stops intake
// is a frame-completing byte meeting a full result register that the sink has not taken.
// The user writes batch_length through the cfg port only while the block is idle (not enforced).
// depends on adfp_pkg and adfp_frame_unit
module air_data_frame_parser_core #(
	parameter int unsigned HEX_DIGITS = adfp_pkg::HEX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// byte input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [adfp_pkg::CHAN_W-1:0]   channel,
	output logic [adfp_pkg::WORD_W-1:0]   raw_word,
	output logic                          batch_end,
	// batch length register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [adfp_pkg::COUNT_W-1:0]  batch_length
);
	import adfp_pkg::*;

	// input stage
	logic               valid_s1;
	logic [7:0]         byte_s1;

	// batch length register
	logic [COUNT_W-1:0] batch_length_q;

	// result register
	logic               out_valid_q;
	frame_result_t      result_q;

	logic               produce;
	logic               advance;
	frame_result_t      result;

	// the stage-1 byte moves on unless it finishes a frame while the result slot is still full
	assign advance   = valid_s1 && (!produce || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// byte payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_length_q <= BATCH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			batch_length_q <= batch_length;
		end
	end

	// frame tracking and counting
	adfp_frame_unit #(
		.HEX_DIGITS(HEX_DIGITS)
	) u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.rx_byte      (byte_s1),
		.batch_length (batch_length_q),
		.produce      (produce),
		.result       (result)
	);

	// result slot: loads on a completed frame, clears once the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign channel   = result_q.channel;
	assign raw_word  = result_q.raw_word;
	assign batch_end = result_q.batch_end;

endmodule

/* rtl/adfp_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the air data frame parser, bound to the top level
// depends on adfp_pkg and air_data_frame_parser_core
module adfp_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [adfp_pkg::CHAN_W-1:0]   channel,
	input  logic [adfp_pkg::WORD_W-1:0]   raw_word,
	input  logic                          batch_end,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [adfp_pkg::COUNT_W-1:0]  batch_length
);
	import adfp_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(raw_word)
			&& $stable(batch_end))
		else $error("result word changed while stalled");

	// channel code stays in the defined range
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel <= CHAN_UNKNOWN)
		else $error("channel code out of range");

	// a fresh result follows an accepted carriage return that passed the input register and the frame update
	a_rose_after_cr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (rx_byte == RETURN_BYTE), 2))
		else $error("result without a preceding carriage return");

	// a register write carries a defined value
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !$isunknown(batch_length))
		else $error("batch length write with unknown data");

endmodule

bind air_data_frame_parser_core adfp_checker u_adfp_checker (.*);
